// ===== hw/rtl/pal_pkg.sv =====
// Shared types and constants for the positional array list unit.
`default_nettype none
package pal_pkg;

  localparam int unsigned CapacityDefault = 16;
  localparam int unsigned KeyBitsDefault  = 64;

  localparam int unsigned CmdBits   = 2;
  localparam int unsigned PosBits   = 5;
  localparam int unsigned KeyWidth  = 64;
  localparam int unsigned InBits    = CmdBits + PosBits + KeyWidth;
  localparam int unsigned InBytes   = (InBits + 7) / 8;
  localparam int unsigned StatBits  = 2;
  localparam int unsigned IdxBits   = 4;
  localparam int unsigned CntBits   = 5;
  localparam int unsigned OutBits   = StatBits + IdxBits + CntBits;
  localparam int unsigned OutBytes  = (OutBits + 7) / 8;

  typedef enum logic [CmdBits-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_t;

  typedef enum logic [StatBits-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_op_t;

endpackage
`default_nettype wire

// ===== hw/rtl/positional_array_list_unit.sv =====
// Top level of the positional array list: a row of key cells and the command logic.
// The result word is captured in the output register at the edge that accepts the command word.
// Throughput: one command word per cycle unless output stalls; cells shift or compare in parallel.
// The search result comes from a priority encoder over the cell match flags.
// Reset clears the entry count and the output valid; cell keys stay undefined until written.
`default_nettype none
module positional_array_list_unit #(
  parameter int unsigned CAPACITY = pal_pkg::CapacityDefault,
  parameter int unsigned KEY_BITS = pal_pkg::KeyBitsDefault
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // Fields from bit 0: command[1:0], position[6:2], key[70:7], zero fill.
  input  wire logic [pal_pkg::InBytes*8-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // Fields from bit 0: status[1:0], found_index[5:2], entry_count[10:6], zero fill.
  output logic      [pal_pkg::OutBytes*8-1:0] m_tdata
);
  import pal_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CmpW = (CntW > PosBits) ? CntW : PosBits;

  logic [CmdBits-1:0]  command;
  logic [PosBits-1:0]  position;
  logic [KEY_BITS-1:0] key;

  assign command  = s_tdata[CmdBits-1:0];
  assign position = s_tdata[CmdBits+PosBits-1:CmdBits];
  assign key      = s_tdata[CmdBits+PosBits+KEY_BITS-1:CmdBits+PosBits];

  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] cnt_ext;
  logic            accept;
  cell_op_t        op;
  status_t         status_next;
  logic [IdxW-1:0] hit_idx;
  logic            hit;

  logic [KEY_BITS-1:0] cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_match;

  logic                m_valid_next;
  status_t             status;
  logic [IdxW-1:0]     found_idx;
  logic [IdxW+IdxBits-1:0] found_wide;
  logic [CntW+CntBits-1:0] cnt_wide;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign pos_ext  = CmpW'(position);
  assign cnt_ext  = CmpW'(count);

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        hit     = 1'b1;
        hit_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    op          = '0;
    count_next  = count;
    status_next = ST_RANGE;
    unique case (cmd_t'(command))
      CMD_INSERT: begin
        if (count == CntW'(CAPACITY)) begin
          status_next = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          status_next = ST_RANGE;
        end else begin
          status_next = ST_OK;
          op.ins      = accept;
          count_next  = count + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          status_next = ST_RANGE;
        end else begin
          status_next = ST_OK;
          op.rem      = accept;
          count_next  = count - 1'b1;
        end
      end
      CMD_SEARCH: begin
        status_next = hit ? ST_OK : ST_MISS;
      end
      default: begin
        status_next = ST_RANGE;
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_BITS-1:0] left_entry;
    logic [KEY_BITS-1:0] right_entry;
    if (g == 0) begin : g_first
      assign left_entry = key;
    end else begin : g_mid_l
      assign left_entry = cell_entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_entry = cell_entry[g];
    end else begin : g_mid_r
      assign right_entry = cell_entry[g+1];
    end
    pal_cell #(
      .INDEX    (g),
      .CNT_W    (CntW),
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk         (clk),
      .op          (op),
      .pos         (CntW'(pos_ext)),
      .count       (count),
      .key         (key),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (cell_entry[g]),
      .match       (cell_match[g])
    );
  end

  assign m_valid_next = accept || (m_tvalid && !m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_valid_next;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      found_idx <= ((cmd_t'(command) == CMD_SEARCH) && hit) ? hit_idx : '0;
    end
  end

  assign found_wide = {{IdxBits{1'b0}}, found_idx};
  assign cnt_wide   = {{CntBits{1'b0}}, count};
  assign m_tdata    = {{(OutBytes*8 - OutBits){1'b0}},
                       cnt_wide[CntBits-1:0], found_wide[IdxBits-1:0], status};

endmodule
`default_nettype wire

// ===== hw/rtl/pal_cell.sv =====
// One list cell: holds one key, shifts with its neighbors and compares.
`default_nettype none
module pal_cell #(
  parameter int unsigned INDEX    = 0,
  parameter int unsigned CNT_W    = 5,
  parameter int unsigned KEY_BITS = 64
) (
  input  wire logic                  clk,
  input  wire pal_pkg::cell_op_t     op,
  input  wire logic [CNT_W-1:0]      pos,
  input  wire logic [CNT_W-1:0]      count,
  input  wire logic [KEY_BITS-1:0]   key,
  input  wire logic [KEY_BITS-1:0]   left_entry,
  input  wire logic [KEY_BITS-1:0]   right_entry,
  output logic      [KEY_BITS-1:0]   entry,
  output logic                       match
);
  import pal_pkg::*;

  localparam logic [CNT_W-1:0] Idx = CNT_W'(INDEX);

  logic [KEY_BITS-1:0] entry_next;
  logic                load;

  always_comb begin
    entry_next = entry;
    load       = 1'b0;
    if (op.ins) begin
      if (Idx == pos) begin
        entry_next = key;
        load       = 1'b1;
      end else if (Idx > pos) begin
        entry_next = left_entry;
        load       = 1'b1;
      end
    end else if (op.rem) begin
      if (Idx >= pos) begin
        entry_next = right_entry;
        load       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry <= entry_next;
    end
  end

  assign match = (entry == key) && (Idx < count);

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the positional array list unit: directed table, then random words.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pal_pkg::*;

  localparam int unsigned Cap         = CapacityDefault;
  localparam int unsigned RandomWords = 2000;
  localparam int unsigned PhaseLen    = 150;
  localparam int unsigned QuietFirst  = 500;
  localparam int unsigned QuietLast   = 900;
  localparam int unsigned PausePoint  = 1200;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned ReportMax   = 10;
  localparam int unsigned PoolSize    = 6;
  localparam logic [CmdBits-1:0] CMD_SPARE = 2'd3;
  localparam logic [KeyWidth-1:0] KeyOnes  = '1;
  localparam logic [KeyWidth-1:0] KeyFives = 64'h5555_5555_5555_5555;
  localparam logic [KeyWidth-1:0] KeyAs    = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [KeyWidth-1:0] KeyTop   = 64'h8000_0000_0000_0000;

  typedef struct packed {
    status_t              status;
    logic [IdxBits-1:0]   idx;
    logic [CntBits-1:0]   cnt;
  } list_result_t;

  typedef struct packed {
    logic [CmdBits-1:0]   cmd;
    logic [PosBits-1:0]   pos;
    logic [KeyWidth-1:0]  key;
    logic [4:0]           reps;
    logic                 pinned;
    list_result_t         res;
  } plan_row_t;

  // Rows with pinned set carry their result; the rest are checked against the list model.
  localparam plan_row_t PlanRows [17] = '{
    '{CMD_REMOVE, 5'd0,  64'd0,    5'd1,  1'b1, '{ST_RANGE, 4'd0,  5'd0}},
    '{CMD_SEARCH, 5'd0,  64'd0,    5'd1,  1'b1, '{ST_MISS,  4'd0,  5'd0}},
    '{CMD_SPARE,  5'd31, KeyOnes,  5'd1,  1'b1, '{ST_RANGE, 4'd0,  5'd0}},
    '{CMD_INSERT, 5'd0,  KeyOnes,  5'd1,  1'b1, '{ST_OK,    4'd0,  5'd1}},
    '{CMD_INSERT, 5'd0,  64'd0,    5'd1,  1'b1, '{ST_OK,    4'd0,  5'd2}},
    '{CMD_SEARCH, 5'd31, KeyOnes,  5'd1,  1'b1, '{ST_OK,    4'd1,  5'd2}},
    '{CMD_INSERT, 5'd2,  KeyFives, 5'd1,  1'b0, '{ST_OK,    4'd0,  5'd0}},
    '{CMD_INSERT, 5'd31, 64'd0,    5'd1,  1'b1, '{ST_RANGE, 4'd0,  5'd3}},
    '{CMD_INSERT, 5'd4,  64'd0,    5'd1,  1'b1, '{ST_RANGE, 4'd0,  5'd3}},
    '{CMD_REMOVE, 5'd31, 64'd0,    5'd1,  1'b1, '{ST_RANGE, 4'd0,  5'd3}},
    '{CMD_REMOVE, 5'd3,  KeyOnes,  5'd1,  1'b1, '{ST_RANGE, 4'd0,  5'd3}},
    '{CMD_INSERT, 5'd0,  KeyTop,   5'd13, 1'b0, '{ST_OK,    4'd0,  5'd0}},
    '{CMD_INSERT, 5'd0,  64'd0,    5'd1,  1'b1, '{ST_FULL,  4'd0,  5'd16}},
    '{CMD_SEARCH, 5'd0,  KeyFives, 5'd1,  1'b0, '{ST_OK,    4'd0,  5'd0}},
    '{CMD_SEARCH, 5'd0,  KeyAs,    5'd1,  1'b1, '{ST_MISS,  4'd0,  5'd16}},
    '{CMD_REMOVE, 5'd16, 64'd0,    5'd1,  1'b1, '{ST_RANGE, 4'd0,  5'd16}},
    '{CMD_REMOVE, 5'd15, KeyOnes,  5'd1,  1'b0, '{ST_OK,    4'd0,  5'd0}}
  };

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [InBytes*8-1:0]    s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OutBytes*8-1:0]   m_tdata;

  logic                    pinned_flag = 1'b0;
  list_result_t            pinned_res = '0;
  logic                    idle_on = 1'b1;

  logic [KeyWidth-1:0]     list_keys [Cap];
  int unsigned             list_len = 0;
  list_result_t            pending_q [$];
  logic [KeyWidth-1:0]     key_pool [PoolSize];

  int unsigned             mismatches = 0;
  int unsigned             stall_cycles = 0;
  int unsigned             words_in = 0;
  int unsigned             words_out = 0;
  int unsigned             peak_len = 0;
  int unsigned             status_seen [4] = '{default: 0};

  positional_array_list_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic apply_command(input logic [CmdBits-1:0] c, input logic [PosBits-1:0] p,
                               input logic [KeyWidth-1:0] k, output list_result_t r);
    int unsigned i;
    r = '{ST_RANGE, '0, '0};
    unique case (c)
      CMD_INSERT: begin
        if (list_len >= Cap) begin
          r.status = ST_FULL;
        end else if (p <= list_len) begin
          for (i = list_len; i > p; i--) list_keys[i] = list_keys[i-1];
          list_keys[p] = k;
          list_len++;
          r.status = ST_OK;
        end
      end
      CMD_REMOVE: begin
        if (p < list_len) begin
          for (i = p; i + 1 < list_len; i++) list_keys[i] = list_keys[i+1];
          list_len--;
          r.status = ST_OK;
        end
      end
      CMD_SEARCH: begin
        r.status = ST_MISS;
        for (i = 0; i < list_len; i++) begin
          if (list_keys[i] == k) begin
            r.status = ST_OK;
            r.idx = i[IdxBits-1:0];
            break;
          end
        end
      end
      default: r.status = ST_RANGE;
    endcase
    r.cnt = list_len[CntBits-1:0];
  endtask

  task automatic send_word(input logic [CmdBits-1:0] c, input logic [PosBits-1:0] p,
                           input logic [KeyWidth-1:0] k, input logic pin,
                           input list_result_t res, input bit hold);
    if (hold || (idle_on && $urandom_range(99) < 28)) begin
      s_tvalid <= 1'b0;
      if (hold) begin
        do @(posedge clk); while (pending_q.size() != 0);
      end else begin
        @(posedge clk);
      end
    end
    s_tvalid    <= 1'b1;
    s_tdata     <= {{(InBytes*8-InBits){1'b0}}, k, p, c};
    pinned_flag <= pin;
    pinned_res  <= res;
    do @(posedge clk); while (!s_tready);
  endtask

  // Alternating phases favor filling or draining so that both full and empty lists come up.
  task automatic pick_random(input int unsigned n, output logic [CmdBits-1:0] c,
                             output logic [PosBits-1:0] p, output logic [KeyWidth-1:0] k);
    int unsigned r, len, ins_cut, rem_cut;
    len = list_len;
    if ((n / PhaseLen) % 2 == 0) begin
      ins_cut = 55;
      rem_cut = 75;
    end else begin
      ins_cut = 25;
      rem_cut = 70;
    end
    r = $urandom_range(99);
    if (r < ins_cut) c = CMD_INSERT;
    else if (r < rem_cut) c = CMD_REMOVE;
    else if (r < 97) c = CMD_SEARCH;
    else c = CMD_SPARE;
    if ($urandom_range(9) == 0) p = PosBits'($urandom_range(31, 0));
    else if (c == CMD_INSERT) p = PosBits'($urandom_range(len, 0));
    else p = PosBits'($urandom_range(len > 0 ? len - 1 : 0, 0));
    r = $urandom_range(99);
    if (c == CMD_SEARCH && len > 0 && r < 60) k = list_keys[$urandom_range(len - 1, 0)];
    else if ((c == CMD_SEARCH && r < 80) || (c != CMD_SEARCH && r < 35))
      k = key_pool[$urandom_range(PoolSize - 1, 0)];
    else k = {$urandom, $urandom};
  endtask

  always @(posedge clk) begin
    m_tready <= idle_on ? ($urandom_range(99) >= 22) : 1'b1;
  end

  always @(posedge clk) begin
    list_result_t want, got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        apply_command(s_tdata[CmdBits-1:0], s_tdata[CmdBits +: PosBits],
                      s_tdata[CmdBits+PosBits +: KeyWidth], want);
        if (pinned_flag) want = pinned_res;
        pending_q.push_back(want);
        words_in++;
      end
      if (m_tvalid && m_tready) begin
        got.status = status_t'(m_tdata[StatBits-1:0]);
        got.idx    = m_tdata[StatBits +: IdxBits];
        got.cnt    = m_tdata[StatBits+IdxBits +: CntBits];
        words_out++;
        status_seen[got.status]++;
        if (got.cnt > peak_len) peak_len = int'(got.cnt);
        if (pending_q.size() == 0) begin
          if (mismatches < ReportMax)
            $display("%0t: unexpected result word status %0d index %0d count %0d",
                     $realtime, got.status, got.idx, got.cnt);
          mismatches++;
        end else begin
          want = pending_q.pop_front();
          if (got.status !== want.status || got.idx !== want.idx || got.cnt !== want.cnt) begin
            if (mismatches < ReportMax)
              $display("%0t: word %0d: expected %0d %0d %0d, got %0d %0d %0d",
                       $realtime, words_out, want.status, want.idx, want.cnt,
                       got.status, got.idx, got.cnt);
            mismatches++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("positional_array_list_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n, r;
    logic [CmdBits-1:0] c;
    logic [PosBits-1:0] p;
    logic [KeyWidth-1:0] k;
    key_pool[0] = '0;
    key_pool[1] = KeyOnes;
    for (n = 2; n < PoolSize; n++) key_pool[n] = {$urandom, $urandom};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (PlanRows[i]) begin
      for (r = 0; r < PlanRows[i].reps; r++)
        send_word(PlanRows[i].cmd, PlanRows[i].pos, PlanRows[i].key + r,
                  PlanRows[i].pinned, PlanRows[i].res, 1'b0);
    end
    for (n = 0; n < RandomWords; n++) begin
      idle_on <= !(n >= QuietFirst && n < QuietLast);
      pick_random(n, c, p, k);
      send_word(c, p, k, 1'b0, '0, n == PausePoint);
    end
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d command words, received %0d result words, peak list length %0d.",
             words_in, words_out, peak_len);
    $display("Results by status: ok %0d, full %0d, out of range %0d, not found %0d.",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_RANGE],
             status_seen[ST_MISS]);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("positional_array_list_unit: match");
    end else begin
      $display("positional_array_list_unit: mismatch");
    end
    $finish;
  end

endmodule
